[hdl/hpc_pkg.sv]
// package for the hashed position cache: sizes, controller states, command/status structs
// used by hpc_ctrl, hpc_datapath and hashed_position_cache_fifo
package hpc_pkg;
    localparam int BUCKET_COUNT_DEF = 4096;
    localparam int POOL_ENTRIES_DEF = 1024;
    localparam int KEY_WORDS        = 5;
    localparam int WORD_W           = 64;
    localparam int KEY_W            = KEY_WORDS * WORD_W;
    localparam int RES_W            = 2;
    localparam int DEPTH_W          = 8;
    localparam logic OP_LOOKUP      = 1'b0;
    localparam logic OP_STORE       = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HEAD_RD,
        ST_HEAD_WAIT,
        ST_ENT_RD,
        ST_ENT_WAIT,
        ST_ENT_CHK,
        ST_EVICT_RD,
        ST_EVICT_WAIT,
        ST_EVICT_CHK,
        ST_INSERT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic take_head;
        logic follow_link;
        logic set_hit;
        logic evict_rd;
        logic evict_bucket_rd;
        logic evict_clear;
        logic insert;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_store;
        logic head_valid;
        logic entry_match;
        logic link_ok;
        logic pool_full;
        logic evict_head_match;
    } status_t;

    function automatic logic [63:0] bit_pack(input logic [63:0] x);
        logic [63:0] p;
        p = (x >> 4) & ~64'h1FF;
        p = p | (x & 64'h1F);
        p = p | ((x >> 2) & 64'h1E0);
        return p;
    endfunction
endpackage

[hdl/hpc_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module hpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/hpc_ctrl.sv]
// controller state machine for the hashed position cache
// depends on hpc_pkg
module hpc_ctrl
    import hpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_take,
    input  logic    out_free,
    input  status_t sts,
    output cmd_t    cmd,
    output logic    busy,
    output logic    out_load
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:      if (sts.clear_done) state_next = ST_IDLE;
            ST_IDLE:       if (in_take) state_next = ST_HEAD_RD;
            ST_HEAD_RD:    state_next = ST_HEAD_WAIT;
            ST_HEAD_WAIT:
            begin
                if (sts.is_store)
                begin
                    state_next = sts.pool_full ? ST_EVICT_RD : ST_INSERT;
                end
                else
                begin
                    state_next = sts.head_valid ? ST_ENT_RD : ST_OUT;
                end
            end
            ST_ENT_RD:     state_next = ST_ENT_WAIT;
            ST_ENT_WAIT:   state_next = ST_ENT_CHK;
            ST_ENT_CHK:
            begin
                if (sts.entry_match || !sts.link_ok) state_next = ST_OUT;
                else state_next = ST_ENT_RD;
            end
            ST_EVICT_RD:   state_next = ST_EVICT_WAIT;
            ST_EVICT_WAIT: state_next = ST_EVICT_CHK;
            ST_EVICT_CHK:  state_next = ST_INSERT;
            ST_INSERT:     state_next = ST_OUT;
            ST_OUT:        if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        busy     = 1'b1;
        out_load = 1'b0;
        unique case (state_reg)
            ST_CLEAR:      cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                busy          = 1'b0;
                cmd.load_item = in_take;
            end
            ST_HEAD_RD:    ;
            ST_HEAD_WAIT:  cmd.take_head = 1'b1;
            ST_ENT_RD:     ;
            ST_ENT_WAIT:   ;
            ST_ENT_CHK:
            begin
                cmd.set_hit     = sts.entry_match;
                cmd.follow_link = !sts.entry_match;
            end
            ST_EVICT_RD:   cmd.evict_rd = 1'b1;
            ST_EVICT_WAIT: cmd.evict_bucket_rd = 1'b1;
            ST_EVICT_CHK:  cmd.evict_clear = sts.evict_head_match;
            ST_INSERT:     cmd.insert = 1'b1;
            ST_OUT:        out_load = out_free;
            default:       ;
        endcase
    end
endmodule

[hdl/hpc_datapath.sv]
// datapath: bucket heads, entry pool memories, walk pointer and compare logic
// depends on hpc_pkg and hpc_ram
module hpc_datapath
    import hpc_pkg::*;
#(
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [RES_W-1:0]   draw_code,
    input  logic               op,
    input  logic [WORD_W-1:0]  key_word0,
    input  logic [WORD_W-1:0]  key_word1,
    input  logic [WORD_W-1:0]  key_word2,
    input  logic [WORD_W-1:0]  key_word3,
    input  logic [WORD_W-1:0]  key_word4,
    input  logic [DEPTH_W-1:0] query_depth,
    input  logic [RES_W-1:0]   store_result,
    input  logic [DEPTH_W-1:0] store_depth,
    output status_t            sts,
    output logic               hit_val,
    output logic [RES_W-1:0]   res_val
);
    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int SW = $clog2(POOL_ENTRIES);
    localparam int PW = SW + 1;  // slot plus empty marker
    localparam int EW = KEY_W + RES_W + DEPTH_W + BW + PW;
    localparam logic [PW-1:0] NO_SLOT = PW'(POOL_ENTRIES);

    logic               op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [DEPTH_W-1:0] qd_reg;
    logic [RES_W-1:0]   sres_reg;
    logic [DEPTH_W-1:0] sdep_reg;
    logic [BW-1:0]      bucket_reg;
    logic [PW-1:0]      cur_reg, cur_next;
    logic [PW-1:0]      fill_reg;
    logic [SW-1:0]      oldest_reg;
    logic [BW-1:0]      clr_reg;
    logic               clr_done_reg;
    logic               hit_reg;
    logic [RES_W-1:0]   res_reg;
    logic [63:0]        packed_hash;

    // bucket head memory
    logic          head_we;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [PW-1:0] head_wdata, head_rdata;

    // entry memory: key, result, depth, bucket, older link
    logic          ent_we;
    logic [SW-1:0] ent_raddr;
    logic [EW-1:0] ent_wdata, ent_rdata;
    logic [KEY_W-1:0]   e_key;
    logic [RES_W-1:0]   e_res;
    logic [DEPTH_W-1:0] e_dep;
    logic [BW-1:0]      e_bkt;
    logic [PW-1:0]      e_link;
    logic [SW-1:0]      cur_slot, link_slot, ins_slot, rank_cur, rank_nxt;
    logic               qualify;

    assign packed_hash = bit_pack(key_word0 ^ key_word1);
    assign {e_key, e_res, e_dep, e_bkt, e_link} = ent_rdata;
    assign cur_slot  = cur_reg[SW-1:0];
    assign link_slot = e_link[SW-1:0];
    assign ins_slot  = (fill_reg < PW'(POOL_ENTRIES)) ? fill_reg[SW-1:0] : oldest_reg;
    // ranks relative to oldest, modulo pool size
    assign rank_cur  = cur_slot - oldest_reg;
    assign rank_nxt  = link_slot - oldest_reg;
    assign qualify   = (e_res == draw_code) ? (qd_reg <= e_dep) : (qd_reg >= e_dep);

    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = bucket_reg;
        head_wdata = NO_SLOT;
        head_raddr = bucket_reg;
        if (cmd.clear_step)
        begin
            head_we    = 1'b1;
            head_waddr = clr_reg;
        end
        else if (cmd.evict_clear)
        begin
            head_we    = 1'b1;
            head_waddr = e_bkt;
        end
        else if (cmd.insert)
        begin
            head_we    = 1'b1;
            head_wdata = {1'b0, ins_slot};
        end
        if (cmd.evict_bucket_rd)
        begin
            head_raddr = e_bkt;
        end
    end

    assign ent_we    = cmd.insert;
    // victim entry stays on the read port until its bucket head is checked
    assign ent_raddr = (cmd.evict_rd || cmd.evict_bucket_rd) ? oldest_reg : cur_slot;
    // older link is the head read back in the head-wait state, held in cur_reg
    assign ent_wdata = {key_reg, sres_reg, sdep_reg, bucket_reg, cur_reg};

    hpc_ram #(.WIDTH(PW), .DEPTH(BUCKET_COUNT)) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    hpc_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_entry (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ins_slot),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.take_head)
        begin
            cur_next = head_rdata;
        end
        else if (cmd.follow_link)
        begin
            cur_next = e_link;
        end
        else if (cmd.evict_clear && e_bkt == bucket_reg)
        begin
            // own bucket just lost its only entry
            cur_next = NO_SLOT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= op;
            key_reg    <= {key_word4, key_word3, key_word2, key_word1, key_word0};
            qd_reg     <= query_depth;
            sres_reg   <= store_result;
            sdep_reg   <= store_depth;
            bucket_reg <= packed_hash[BW-1:0];
        end
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            oldest_reg   <= '0;
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
            hit_reg      <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == BW'(BUCKET_COUNT - 1))
                begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (cmd.load_item)
            begin
                hit_reg <= 1'b0;
                res_reg <= '0;
            end
            if (cmd.set_hit)
            begin
                hit_reg <= 1'b1;
                res_reg <= e_res;
            end
            if (cmd.insert)
            begin
                if (fill_reg < PW'(POOL_ENTRIES))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                else
                begin
                    oldest_reg <= (oldest_reg == SW'(POOL_ENTRIES - 1)) ? '0
                                                                          : oldest_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        sts.clear_done       = clr_done_reg || (cmd.clear_step
                               && clr_reg == BW'(BUCKET_COUNT - 1));
        sts.is_store         = (op_reg == OP_STORE);
        sts.head_valid       = (head_rdata < NO_SLOT);
        sts.entry_match      = (e_key == key_reg) && qualify;
        sts.link_ok          = (e_link < NO_SLOT) && (rank_nxt < rank_cur);
        sts.pool_full        = !(fill_reg < PW'(POOL_ENTRIES));
        sts.evict_head_match = (head_rdata == {1'b0, oldest_reg});
    end

    assign hit_val = hit_reg;
    assign res_val = res_reg;
endmodule

[hdl/hashed_position_cache_fifo.sv]
// hashed position cache with fifo replacement, top level
// a store reads the bucket head and inserts, evicting the oldest entry first once the pool is full;
// a lookup reads the bucket head, then one pool entry per chain entry walked
// throughput: one item at a time; the next item is accepted in the cycle after the result
// is loaded, so walk length through the entry ram port sets the rate
// reset: asynchronous active low; a pass that clears every bucket head follows,
// during which no item is accepted; draw_code resets to 0
// depends on hpc_pkg, hpc_ctrl, hpc_datapath, hpc_ram
module hashed_position_cache_fifo
    import hpc_pkg::*;
#(
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [WORD_W-1:0]  key_word0,
    input  logic [WORD_W-1:0]  key_word1,
    input  logic [WORD_W-1:0]  key_word2,
    input  logic [WORD_W-1:0]  key_word3,
    input  logic [WORD_W-1:0]  key_word4,
    input  logic [DEPTH_W-1:0] query_depth,
    input  logic [RES_W-1:0]   store_result,
    input  logic [DEPTH_W-1:0] store_depth,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [RES_W-1:0]   found_result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RES_W-1:0]   cfg_data
);
    cmd_t             cmd;
    status_t          sts;
    logic             busy, out_load, in_take, out_free;
    logic             hit_val;
    logic [RES_W-1:0] res_val;
    logic [RES_W-1:0] draw_reg;
    logic             ov_reg;
    logic             hit_reg;
    logic [RES_W-1:0] fr_reg;

    assign in_stall  = busy;
    assign in_take   = in_valid && !busy;
    assign out_free  = !ov_reg || !out_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_reg <= '0;
            ov_reg   <= 1'b0;
            hit_reg  <= 1'b0;
            fr_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                draw_reg <= cfg_data;
            end
            if (out_load)
            begin
                ov_reg  <= 1'b1;
                hit_reg <= hit_val;
                fr_reg  <= res_val;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = ov_reg;
    assign hit          = hit_reg;
    assign found_result = fr_reg;

    hpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .out_load (out_load)
    );

    hpc_datapath #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .draw_code    (draw_reg),
        .op           (op),
        .key_word0    (key_word0),
        .key_word1    (key_word1),
        .key_word2    (key_word2),
        .key_word3    (key_word3),
        .key_word4    (key_word4),
        .query_depth  (query_depth),
        .store_result (store_result),
        .store_depth  (store_depth),
        .sts          (sts),
        .hit_val      (hit_val),
        .res_val      (res_val)
    );
endmodule

[tb/hashed_position_cache_fifo_test.sv]
// self-checking testbench for hashed_position_cache_fifo: directed and random lookups/stores,
// a predictor of the chained hash table with fifo replacement, and a result scoreboard
// depends on hpc_pkg and the hashed_position_cache_fifo rtl
`timescale 1ns / 100ps

class cache_scoreboard;
    logic [63:0] slot_key [0:5119];
    logic [1:0]  slot_result [0:1023];
    logic [7:0]  slot_depth [0:1023];
    int unsigned slot_bucket [0:1023];
    int unsigned slot_older [0:1023];
    int unsigned bucket_head [0:4095];
    int unsigned used_slots;
    int unsigned next_victim;
    logic [1:0]  draw_code;
    logic        want_hit [$];
    logic [1:0]  want_result [$];
    int          mismatches;

    function new();
        for (int b = 0; b < 4096; b++)
            bucket_head[b] = 1024;
        used_slots = 0;
        next_victim = 0;
        draw_code = 0;
        mismatches = 0;
    endfunction

    function int unsigned bucket_index(logic [63:0] w0, logic [63:0] w1);
        logic [63:0] x;
        logic [63:0] p;
        x = w0 ^ w1;
        p = {4'b0, x[63:4]} & ~64'h1FF;
        p = p | (x & 64'h1F) | ({2'b0, x[63:2]} & 64'h1E0);
        return p[11:0];
    endfunction

    function int unsigned age(int unsigned s);
        return (s >= next_victim) ? s - next_victim : s + 1024 - next_victim;
    endfunction

    function void note_item(logic op, logic [63:0] k [5], logic [7:0] qd,
                            logic [1:0] sr, logic [7:0] sd);
        int unsigned h;
        int unsigned cur;
        int unsigned slot;
        int unsigned steps;
        logic        eq;
        logic        found;
        logic [1:0]  fr;
        h = bucket_index(k[0], k[1]);
        found = 0;
        fr = 0;
        if (op == hpc_pkg::OP_LOOKUP) begin
            cur = bucket_head[h];
            steps = 0;
            while (cur < 1024 && steps < 1024 && !found) begin
                eq = 1;
                for (int i = 0; i < 5; i++)
                    if (slot_key[cur*5+i] !== k[i])
                        eq = 0;
                if (eq && ((slot_result[cur] == draw_code && qd <= slot_depth[cur]) ||
                           (slot_result[cur] != draw_code && qd >= slot_depth[cur]))) begin
                    found = 1;
                    fr = slot_result[cur];
                end
                else if (slot_older[cur] >= 1024 || age(slot_older[cur]) >= age(cur))
                    break;
                else begin
                    cur = slot_older[cur];
                    steps++;
                end
            end
        end
        else begin
            if (used_slots < 1024) begin
                slot = used_slots;
                used_slots++;
            end
            else begin
                slot = next_victim;
                if (bucket_head[slot_bucket[slot]] == slot)
                    bucket_head[slot_bucket[slot]] = 1024;
                next_victim = (next_victim + 1 >= 1024) ? 0 : next_victim + 1;
            end
            slot_older[slot] = bucket_head[h];
            bucket_head[h] = slot;
            slot_bucket[slot] = h;
            for (int i = 0; i < 5; i++)
                slot_key[slot*5+i] = k[i];
            slot_result[slot] = sr;
            slot_depth[slot] = sd;
        end
        want_hit.push_back(found);
        want_result.push_back(fr);
    endfunction

    function void check_result(logic got_hit, logic [1:0] got_result);
        logic       eh;
        logic [1:0] er;
        if (want_hit.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result hit=%0d found_result=%0d", got_hit, got_result);
            return;
        end
        eh = want_hit.pop_front();
        er = want_result.pop_front();
        if (got_hit !== eh || got_result !== er) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected hit=%0d found_result=%0d, got hit=%0d found_result=%0d",
                         eh, er, got_hit, got_result);
        end
    endfunction
endclass

module hashed_position_cache_fifo_test;
    import hpc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [63:0] key_word0, key_word1, key_word2, key_word3, key_word4;
    logic [7:0]  query_depth;
    logic [1:0]  store_result;
    logic [7:0]  store_depth;
    logic        out_valid;
    logic        out_stall;
    logic        hit;
    logic [1:0]  found_result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;

    cache_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  cycles;
    logic [63:0] known_keys [$];

    hashed_position_cache_fifo uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .key_word0(key_word0), .key_word1(key_word1), .key_word2(key_word2),
        .key_word3(key_word3), .key_word4(key_word4), .query_depth(query_depth),
        .store_result(store_result), .store_depth(store_depth),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .found_result(found_result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // receiver: random stall, plus long hold-off when asked
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(hit, found_result);
    end

    // valid was dropped at a falling edge, so wait for another falling edge before driving
    task automatic send_item(logic o, logic [63:0] k [5], logic [7:0] qd,
                             logic [1:0] sr, logic [7:0] sd);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid <= 1'b1;
        op <= o;
        key_word0 <= k[0]; key_word1 <= k[1]; key_word2 <= k[2];
        key_word3 <= k[3]; key_word4 <= k[4];
        query_depth <= qd; store_result <= sr; store_depth <= sd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(o, k, qd, sr, sd);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.want_hit.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_draw_code(logic [1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.draw_code = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly keys from a small pool so lookups hit and chains form
    task automatic random_item();
        logic [63:0] k [5];
        logic        o;
        int          pick;
        o = $urandom_range(1);
        if (known_keys.size() > 0 && $urandom_range(99) < 80)
        begin
            pick = $urandom_range(known_keys.size() / 5 - 1);
            for (int i = 0; i < 5; i++)
                k[i] = known_keys[pick*5+i];
            // same bucket, different key: vary a non-hashed word
            if ($urandom_range(9) == 0)
                k[2 + $urandom_range(2)] ^= 64'h1 << $urandom_range(63);
        end
        else
        begin
            for (int i = 0; i < 5; i++)
                k[i] = rand64();
            if ($urandom_range(3) == 0)
                k[1] = k[0] ^ {52'h0, 12'($urandom)};
            if (known_keys.size() < 200)
                for (int i = 0; i < 5; i++)
                    known_keys.push_back(k[i]);
        end
        send_item(o, k, 8'($urandom), 2'($urandom), 8'($urandom));
    endtask

    initial
    begin
        logic [63:0] k [5];
        sb = new();
        rst_n = 0;
        in_valid = 0; op = 0;
        key_word0 = 0; key_word1 = 0; key_word2 = 0; key_word3 = 0; key_word4 = 0;
        query_depth = 0; store_result = 0; store_depth = 0;
        out_stall = 0; cfg_valid = 0; cfg_data = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, draw and non-draw boundaries, miss, chain in one bucket
        for (int i = 0; i < 5; i++)
            k[i] = '1;
        send_item(OP_LOOKUP, k, 8'd0, 2'd0, 8'd0);
        send_item(OP_STORE, k, 8'd0, 2'd3, 8'd255);
        send_item(OP_LOOKUP, k, 8'd255, 2'd0, 8'd0);
        send_item(OP_LOOKUP, k, 8'd254, 2'd0, 8'd0);
        for (int i = 0; i < 5; i++)
            k[i] = '0;
        send_item(OP_STORE, k, 8'd0, 2'd0, 8'd100);
        send_item(OP_LOOKUP, k, 8'd100, 2'd0, 8'd0);
        send_item(OP_LOOKUP, k, 8'd101, 2'd0, 8'd0);
        send_item(OP_LOOKUP, k, 8'd0, 2'd0, 8'd0);
        send_item(OP_STORE, k, 8'd0, 2'd1, 8'd50);
        send_item(OP_LOOKUP, k, 8'd60, 2'd0, 8'd0);
        send_item(OP_LOOKUP, k, 8'd40, 2'd0, 8'd0);
        k[4] = 64'h8000_0000_0000_0001;
        send_item(OP_STORE, k, 8'd0, 2'd2, 8'd0);
        send_item(OP_LOOKUP, k, 8'd0, 2'd0, 8'd0);
        k[4] = 64'h5;
        send_item(OP_LOOKUP, k, 8'd0, 2'd0, 8'd0);
        write_draw_code(2'd3);
        for (int i = 0; i < 5; i++)
            k[i] = '1;
        send_item(OP_LOOKUP, k, 8'd255, 2'd0, 8'd0);
        send_item(OP_LOOKUP, k, 8'd0, 2'd0, 8'd0);
        for (int i = 0; i < 5; i++)
            k[i] = '0;
        send_item(OP_LOOKUP, k, 8'd100, 2'd0, 8'd0);
        send_item(OP_LOOKUP, k, 8'd0, 2'd0, 8'd0);

        // random phases of mixed lookups and stores under varying sender and receiver stalls
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 63 : 0;
            recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 38 : 0;
            write_draw_code(2'($urandom_range(1, 2) - phase + 2));
            for (int n = 0; n < 610; n++)
            begin
                if (n == 200 && phase == 0)
                begin
                    fork
                        begin
                            hold_off = 1;
                            repeat (300) @(posedge clk);
                            hold_off = 0;
                        end
                    join_none
                end
                if (n == 400)
                    drain();
                random_item();
            end
        end
        write_draw_code(2'd0);

        drain();
        if (sb.mismatches == 0 && sb.want_hit.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
